[rtl/ascn_pkg.sv]
// Shared types and constants of the Annex-B start code normalizer.
`default_nettype none

package ascn_pkg;

    // Start code bytes, the length of the emitted prefix and the full window count.
    localparam logic [7:0] C_SC_ZERO   = 8'h00;
    localparam logic [7:0] C_SC_ONE    = 8'h01;
    localparam logic [2:0] C_PREFIX_LEN = 3'd3;
    localparam logic [1:0] C_LA_FULL   = 2'd3;

    // One input request: a bitstream byte and the end-of-access-unit flag.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    // One result request.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       out_last;
        logic       no_nal_error;
    } t_out;

    // Work item handed from the classifier to the emitter: up to four payload
    // bytes, whether a 00 00 01 prefix goes first, and the end-of-unit flags.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      n;
        logic            prefix;
        logic            last;
        logic            err;
    } t_item;

endpackage

`default_nettype wire

[rtl/ascn_fifo.sv]
// Small register queue that carries work items from the front to the back.
`default_nettype none

module ascn_fifo
    import ascn_pkg::*;
#(
    parameter int P_DEPTH = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_wdata,
    output logic       o_full,
    output logic       o_valid,
    input  wire logic  i_pop,
    output t_item      o_rdata
);

    localparam int L_PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int L_CW = $clog2(P_DEPTH + 1);

    t_item             r_mem [P_DEPTH];
    logic [L_PW-1:0]   r_wr_ptr;
    logic [L_PW-1:0]   r_rd_ptr;
    logic [L_CW-1:0]   r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = (r_count == L_CW'(P_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rdata   = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // Storage is written at the tail pointer.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Pointers wrap at the depth; the count tracks occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == L_PW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == L_PW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/ascn_front.sv]
// Front end: lookahead window, start code detection and work item building.
`default_nettype none

module ascn_front
    import ascn_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_in   i_in_data,
    output logic       o_push,
    output t_item      o_item,
    input  wire logic  i_full
);

    logic [7:0] r_la [3];
    logic [1:0] r_cnt;
    logic       r_inside;
    logic       r_pending;
    logic       r_found;

    logic [7:0] n_la [3];
    logic [1:0] n_cnt;
    logic       n_inside;
    logic       n_pending;
    logic       n_found;

    logic [7:0] w_tmp [4];
    logic       w_sc;
    logic       w_main;
    logic [7:0] w_main_byte;
    logic [1:0] w_flush;
    logic [2:0] w_n;
    logic       w_emit;
    logic       w_accept;

    assign o_in_ready = !i_full;
    assign w_accept   = i_in_valid && o_in_ready;

    // Classify the new byte against the window and work out the next state.
    always_comb begin
        w_tmp[0] = r_la[0];
        w_tmp[1] = r_la[1];
        w_tmp[2] = r_la[2];
        w_tmp[3] = C_SC_ZERO;
        w_tmp[r_cnt] = i_in_data.in_byte;

        // A 01 after two held zeros closes a start code.
        w_sc = 1'b0;
        if (i_in_data.in_byte == C_SC_ONE) begin
            case (r_cnt)
                2'd2:    w_sc = (r_la[0] == C_SC_ZERO) && (r_la[1] == C_SC_ZERO);
                2'd3:    w_sc = (r_la[1] == C_SC_ZERO) && (r_la[2] == C_SC_ZERO);
                default: w_sc = 1'b0;
            endcase
        end

        w_main      = 1'b0;
        w_main_byte = r_la[0];
        n_la        = r_la;
        if (w_sc) begin
            // A non-zero oldest byte is payload; a zero is the fourth start code byte.
            w_main = (r_cnt == C_LA_FULL) && (r_la[0] != C_SC_ZERO);
            n_cnt  = 2'd0;
        end else if (r_cnt == C_LA_FULL) begin
            // Window overflows: the oldest byte is now known to be payload.
            w_main      = 1'b1;
            w_main_byte = w_tmp[0];
            n_la[0]     = w_tmp[1];
            n_la[1]     = w_tmp[2];
            n_la[2]     = w_tmp[3];
            n_cnt       = C_LA_FULL;
        end else begin
            n_la[0] = w_tmp[0];
            n_la[1] = w_tmp[1];
            n_la[2] = w_tmp[2];
            n_cnt   = r_cnt + 2'd1;
        end

        // The last byte flushes whatever the window still holds.
        w_flush = i_in_data.in_last ? n_cnt : 2'd0;
        w_n     = r_inside ? ({2'b00, w_main} + {1'b0, w_flush}) : 3'd0;
        w_emit  = (w_n != 3'd0);

        o_item.bytes[0] = w_main ? w_main_byte : n_la[0];
        o_item.bytes[1] = w_main ? n_la[0] : n_la[1];
        o_item.bytes[2] = w_main ? n_la[1] : n_la[2];
        o_item.bytes[3] = n_la[2];
        o_item.n        = w_n;
        o_item.prefix   = r_pending && w_emit;
        o_item.last     = i_in_data.in_last;

        n_inside  = r_inside || w_sc;
        n_pending = w_sc || (r_pending && !w_emit);
        n_found   = r_found || o_item.prefix;
        o_item.err = !n_found;

        o_push = w_accept && (w_emit || i_in_data.in_last);
    end

    // Window contents need no reset: only held entries are ever read.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_la <= n_la;
        end
    end

    // Control state returns to the search state after each access unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_inside  <= 1'b0;
            r_pending <= 1'b0;
            r_found   <= 1'b0;
        end else if (w_accept) begin
            if (i_in_data.in_last) begin
                r_cnt     <= '0;
                r_inside  <= 1'b0;
                r_pending <= 1'b0;
                r_found   <= 1'b0;
            end else begin
                r_cnt     <= n_cnt;
                r_inside  <= n_inside;
                r_pending <= n_pending;
                r_found   <= n_found;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/ascn_back.sv]
// Back end: expands work items into result requests, one per cycle while the receiver is ready.
`default_nettype none

module ascn_back
    import ascn_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_item_valid,
    input  wire t_item i_item,
    output logic       o_pop,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_out       o_out_data
);

    t_item      r_item;
    logic [2:0] r_idx;
    logic       r_busy;
    logic       r_ovalid;
    t_out       r_odata;

    logic [2:0] w_plen;
    logic [2:0] w_total;
    logic       w_last_idx;
    logic       w_adv;
    logic       w_emit;
    logic       w_load;
    logic [2:0] w_sel;
    t_out       w_res;

    // Sequence length: optional prefix plus payload, or one bare end marker.
    always_comb begin
        w_plen     = r_item.prefix ? C_PREFIX_LEN : 3'd0;
        w_total    = (r_item.n == 3'd0) ? 3'd1 : (w_plen + r_item.n);
        w_last_idx = (r_idx == (w_total - 3'd1));
        w_adv      = !r_ovalid || i_out_ready;
        w_emit     = r_busy && w_adv;
        w_load     = i_item_valid && (!r_busy || (w_emit && w_last_idx));
        o_pop      = w_load;
    end

    // Pick the byte for the current step of the sequence.
    always_comb begin
        w_sel = r_idx - w_plen;
        if (r_item.prefix && (r_idx < C_PREFIX_LEN)) begin
            w_res.out_byte = (r_idx == (C_PREFIX_LEN - 3'd1)) ? C_SC_ONE : C_SC_ZERO;
        end else if (r_item.n == 3'd0) begin
            w_res.out_byte = C_SC_ZERO;
        end else begin
            w_res.out_byte = r_item.bytes[w_sel[1:0]];
        end
        w_res.byte_present = (r_item.n != 3'd0);
        w_res.out_last     = r_item.last && w_last_idx;
        w_res.no_nal_error = r_item.last && w_last_idx && r_item.err;
    end

    // Current item and output register payloads.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
        if (w_emit) begin
            r_odata <= w_res;
        end
    end

    // Sequencer position and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx  <= '0;
                r_busy <= 1'b1;
            end else if (w_emit) begin
                r_idx  <= r_idx + 3'd1;
                r_busy <= !w_last_idx;
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

`default_nettype wire

[rtl/annexb_start_code_normalizer.sv]
// Annex-B start code normalizer: top level joining front end, queue and back end.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one access unit byte per
// request, in_last set on its final byte. Output channel (o_out_valid /
// i_out_ready / o_out_data): one result byte per request. Each non-empty NAL
// unit leaves as 00 00 01 and its payload; leading junk and empty NAL units
// are dropped. The final result of a unit carries out_last, and no_nal_error
// when no NAL unit was found; a unit with nothing to flush ends in a bare
// marker with byte_present low.
// A payload byte is held in a three-byte window until three more bytes arrive
// or the unit ends, then passes the queue, the item and the output registers.
// Throughput: the input takes one byte per cycle; the back end sends one result
// per cycle while the receiver is ready, so the three prefix bytes of each NAL
// unit are absorbed by the P_QUEUE_DEPTH-entry queue between the two halves.
// The input stalls only when that queue is full.
// Reset clears the window state, the queue and the output valid flag. A stalled
// receiver holds the output register; the queue fills and then stalls input.
`default_nettype none

module annexb_start_code_normalizer
    import ascn_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    logic  w_push;
    t_item w_push_item;
    logic  w_full;
    logic  w_q_valid;
    logic  w_pop;
    t_item w_q_item;

    // Front end: window, start code search, work items.
    ascn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (w_push),
        .o_item     (w_push_item),
        .i_full     (w_full)
    );

    // Queue decoupling the two halves.
    ascn_fifo #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_item),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_rdata (w_q_item)
    );

    // Back end: prefix insertion and result sequencing.
    ascn_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_q_valid),
        .i_item       (w_q_item),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

    // The error flag only ever rides on the final result of a unit.
    a_err_on_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.out_last) |-> !o_out_data.no_nal_error)
        else $error("no_nal_error set on a result that is not the last");

    // A bare end marker is always the final result of a unit.
    a_marker_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.byte_present) |-> o_out_data.out_last)
        else $error("bare end marker without out_last");

    // The queue never takes a push while full.
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("work item pushed into a full queue");

    // Reset leaves no result pending.
    a_reset_idle : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the Annex-B start code normalizer.
`default_nettype none

module testbench
    import ascn_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Clock, reset and channel signals.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in  in_data = '0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    // Stimulus, expected output bytes and run control.
    t_in  byte_requests[$];
    t_out expected_bytes[$];
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   sender_hold = 1'b0;
    int   long_stalls_asked = 0;
    int   long_stalls_done = 0;
    int   stall_left = 0;
    int   errors = 0;

    // Predictor state: the start code search window and NAL unit tracking.
    logic [7:0] sc_window[4];
    int         sc_count = 0;
    bit         in_nal_unit = 1'b0;
    bit         prefix_owed = 1'b0;
    bit         nal_emitted = 1'b0;

    annexb_start_code_normalizer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Queue one expected output byte, or a bare end marker when present is low.
    function automatic void expect_byte(logic [7:0] value, logic present);
        t_out item;
        item.out_byte = value;
        item.byte_present = present;
        item.out_last = 1'b0;
        item.no_nal_error = 1'b0;
        expected_bytes.push_back(item);
    endfunction

    // A payload byte is emitted only inside a NAL unit, after the owed prefix.
    function automatic void emit_payload(logic [7:0] value);
        if (!in_nal_unit)
            return;
        if (prefix_owed) begin
            expect_byte(C_SC_ZERO, 1'b1);
            expect_byte(C_SC_ZERO, 1'b1);
            expect_byte(C_SC_ONE, 1'b1);
            prefix_owed = 1'b0;
            nal_emitted = 1'b1;
        end
        expect_byte(value, 1'b1);
    endfunction

    // Work out the output bytes caused by one accepted input request.
    function automatic void predict_normalized(t_in req);
        int first_new;
        int zeros;
        int k;
        t_out tail;
        first_new = expected_bytes.size();
        if (req.in_byte == C_SC_ONE && sc_count >= 2 && sc_window[sc_count - 1] == C_SC_ZERO
                && sc_window[sc_count - 2] == C_SC_ZERO) begin
            // A start code: a third held zero makes it the four-byte form.
            zeros = (sc_count >= 3 && sc_window[sc_count - 3] == C_SC_ZERO) ? 3 : 2;
            for (k = 0; k + zeros < sc_count; k++)
                emit_payload(sc_window[k]);
            sc_count = 0;
            in_nal_unit = 1'b1;
            prefix_owed = 1'b1;
        end else begin
            // Hold the byte; once four are held the oldest is surely payload.
            sc_window[sc_count] = req.in_byte;
            sc_count++;
            if (sc_count == 4) begin
                emit_payload(sc_window[0]);
                for (k = 0; k < 3; k++)
                    sc_window[k] = sc_window[k + 1];
                sc_count = 3;
            end
        end
        if (req.in_last) begin
            // Flush held bytes, mark the end and return to the search state.
            for (k = 0; k < sc_count; k++)
                emit_payload(sc_window[k]);
            if (expected_bytes.size() == first_new)
                expect_byte(8'h00, 1'b0);
            tail = expected_bytes[expected_bytes.size() - 1];
            tail.out_last = 1'b1;
            tail.no_nal_error = !nal_emitted;
            expected_bytes[expected_bytes.size() - 1] = tail;
            sc_count = 0;
            in_nal_unit = 1'b0;
            prefix_owed = 1'b0;
            nal_emitted = 1'b0;
        end
    endfunction

    // Driver: predict on acceptance, then offer the next pending request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                predict_normalized(in_data);
            if (!in_valid || in_ready) begin
                if (byte_requests.size() > 0 && !sender_hold
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_data <= byte_requests.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result, then choose the next ready level.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected result byte=%02h present=%0b last=%0b err=%0b",
                             $realtime, out_data.out_byte, out_data.byte_present,
                             out_data.out_last, out_data.no_nal_error);
                    errors++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (out_data.out_byte !== want.out_byte
                            || out_data.byte_present !== want.byte_present
                            || out_data.out_last !== want.out_last
                            || out_data.no_nal_error !== want.no_nal_error) begin
                        $display("%0t: mismatch expected byte=%02h present=%0b last=%0b err=%0b",
                                 $realtime, want.out_byte, want.byte_present,
                                 want.out_last, want.no_nal_error);
                        $display("%0t:          actual   byte=%02h present=%0b last=%0b err=%0b",
                                 $realtime, out_data.out_byte, out_data.byte_present,
                                 out_data.out_last, out_data.no_nal_error);
                        errors++;
                    end
                end
            end
            // A long hold-off lets the internal queue fill and stall the input.
            if (long_stalls_done != long_stalls_asked) begin
                long_stalls_done = long_stalls_asked;
                stall_left = 300;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Run limit.
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Append one request to the pending stimulus.
    function automatic void add_byte(logic [7:0] value, logic last);
        t_in req;
        req.in_byte = value;
        req.in_last = last;
        byte_requests.push_back(req);
    endfunction

    // Random byte with many zeros and ones to provoke near start codes.
    function automatic logic [7:0] biased_byte();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return C_SC_ZERO;
        if (pick == 3)
            return C_SC_ONE;
        return 8'($urandom_range(0, 255));
    endfunction

    // One access unit: mostly well-formed NAL units, sometimes broken noise.
    function automatic void add_access_unit();
        logic [7:0] unit_bytes[$];
        int nals;
        int n;
        int k;
        if ($urandom_range(0, 4) == 0) begin
            // Broken sequence; the end flag may be missing.
            n = $urandom_range(1, 10);
            for (k = 0; k < n; k++)
                add_byte(biased_byte(), (k == n - 1) && ($urandom_range(0, 1) == 1));
            return;
        end
        for (k = $urandom_range(0, 2); k > 0; k--)
            unit_bytes.push_back(biased_byte());
        nals = $urandom_range(0, 3);
        for (n = 0; n < nals; n++) begin
            if ($urandom_range(0, 1) == 1)
                unit_bytes.push_back(C_SC_ZERO);
            unit_bytes.push_back(C_SC_ZERO);
            unit_bytes.push_back(C_SC_ZERO);
            unit_bytes.push_back(C_SC_ONE);
            for (k = $urandom_range(0, 7); k > 0; k--)
                unit_bytes.push_back(($urandom_range(0, 1) == 1)
                                     ? 8'($urandom_range(0, 255)) : biased_byte());
        end
        for (k = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0; k > 0; k--)
            unit_bytes.push_back(C_SC_ZERO);
        if (unit_bytes.size() == 0)
            unit_bytes.push_back(8'($urandom_range(0, 255)));
        for (k = 0; k < unit_bytes.size(); k++)
            add_byte(unit_bytes[k], k == unit_bytes.size() - 1);
    endfunction

    // Fill one random phase of about the given number of requests.
    function automatic void add_random_phase(int count);
        int target;
        target = byte_requests.size() + count;
        while (byte_requests.size() < target)
            add_access_unit();
    endfunction

    // Wait until every pending request has been accepted.
    task automatic wait_sent();
        while (byte_requests.size() > 0 || in_valid)
            @(negedge i_clk);
    endtask

    // Main sequence.
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: junk only, then a start code that ends the unit.
        add_byte(8'h5A, 1'b1);
        add_byte(C_SC_ZERO, 1'b0);
        add_byte(C_SC_ZERO, 1'b0);
        add_byte(C_SC_ONE, 1'b1);
        // Four-byte start code, three-byte one, an empty NAL unit, trailing zeros.
        add_byte(C_SC_ZERO, 1'b0);
        add_byte(C_SC_ZERO, 1'b0);
        add_byte(C_SC_ZERO, 1'b0);
        add_byte(C_SC_ONE, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(C_SC_ZERO, 1'b0);
        add_byte(C_SC_ZERO, 1'b0);
        add_byte(C_SC_ONE, 1'b0);
        add_byte(C_SC_ZERO, 1'b0);
        add_byte(C_SC_ZERO, 1'b0);
        add_byte(C_SC_ONE, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(C_SC_ZERO, 1'b0);
        add_byte(C_SC_ZERO, 1'b1);
        // Extra leading zero before a four-byte start code, payload of 01.
        add_byte(C_SC_ZERO, 1'b0);
        add_byte(C_SC_ZERO, 1'b0);
        add_byte(C_SC_ZERO, 1'b0);
        add_byte(C_SC_ZERO, 1'b0);
        add_byte(C_SC_ONE, 1'b0);
        add_byte(C_SC_ONE, 1'b1);
        wait_sent();

        // No idling, with one long receiver hold-off while the sender keeps going.
        long_stalls_asked++;
        add_random_phase(30);
        wait_sent();

        // Sender idle most of the time.
        send_idle_pct = 72;
        add_random_phase(28);
        wait_sent();

        // Receiver stalling; midway the sender pauses until the output drains.
        send_idle_pct = 0;
        recv_stall_pct = 72;
        add_random_phase(30);
        while (byte_requests.size() > 15)
            @(negedge i_clk);
        sender_hold = 1'b1;
        while (expected_bytes.size() > 0)
            @(negedge i_clk);
        sender_hold = 1'b0;
        wait_sent();

        // Both sides idle now and then.
        send_idle_pct = 24;
        recv_stall_pct = 24;
        add_random_phase(28);
        wait_sent();

        while (expected_bytes.size() > 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (errors == 0 && expected_bytes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
